FILE: sv/dsm_pkg.sv
`default_nettype none

package dsm_pkg;

   // automaton size
   localparam int NUM_STATES    = 64;
   localparam int ALPHABET_SIZE = 256;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int STATE_W  = 6;
   localparam int SYM_W    = 8;
   localparam int STATUS_W = 3;

   localparam int TBL_DEPTH = NUM_STATES * ALPHABET_SIZE;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int ACC_AW    = $clog2(NUM_STATES);

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE_EDGE   = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_ACCEPT = 2'd1;
   localparam logic [OP_W-1:0] OP_SYMBOL       = 2'd2;
   localparam logic [OP_W-1:0] OP_END          = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CONSUMED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEAD     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

   // classified transaction as held in the queue
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [STATE_W-1:0] from_state;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] to_state;
      logic               accept_value;
      logic               args_ok;     // fields in range for this operation
      logic [TBL_AW-1:0]  edge_addr;   // table slot of a transition write
   } dsm_item_type;

   function automatic logic state_in_range(logic [STATE_W-1:0] s);
      return int'(s) < NUM_STATES;
   endfunction

   function automatic logic sym_in_range(logic [SYM_W-1:0] c);
      return int'(c) < ALPHABET_SIZE;
   endfunction

   function automatic logic [TBL_AW-1:0] tbl_addr(logic [STATE_W-1:0] s,
                                                  logic [SYM_W-1:0]   c);
      return TBL_AW'(s) * TBL_AW'(ALPHABET_SIZE) + TBL_AW'(c);
   endfunction

endpackage

`default_nettype wire

FILE: sv/dsm_front.sv
`default_nettype none

module dsm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dsm_pkg::OP_W-1:0]      req_operation,
   input  logic [dsm_pkg::STATE_W-1:0]   req_from_state,
   input  logic [dsm_pkg::SYM_W-1:0]     req_symbol,
   input  logic [dsm_pkg::STATE_W-1:0]   req_to_state,
   input  logic                          req_accept_value,
   input  logic                          clr_busy,
   input  logic                          pop,
   output logic                          head_valid,
   output dsm_pkg::dsm_item_type         head_item
);
   import dsm_pkg::*;

   localparam int QDEPTH = 2;

   dsm_item_type q_ff [QDEPTH];
   logic [1:0]   cnt_ff, cnt_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         push;
   dsm_item_type item;

   // classify: range checks and transition slot
   always_comb begin
      item.op           = req_operation;
      item.from_state   = req_from_state;
      item.symbol       = req_symbol;
      item.to_state     = req_to_state;
      item.accept_value = req_accept_value;
      item.edge_addr    = tbl_addr(req_from_state, req_symbol);
      case (req_operation)
         OP_WRITE_EDGE: begin
            item.args_ok = state_in_range(req_from_state) &&
                           state_in_range(req_to_state) && sym_in_range(req_symbol);
         end
         OP_WRITE_ACCEPT: begin
            item.args_ok = state_in_range(req_from_state);
         end
         OP_SYMBOL: begin
            item.args_ok = sym_in_range(req_symbol);
         end
         default: begin
            item.args_ok = 1'b1;
         end
      endcase
   end

   assign req_stall  = clr_busy || (cnt_ff == 2'(QDEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (cnt_ff != 2'd0);
   assign head_item  = q_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

FILE: sv/dsm_back.sv
`default_nettype none

module dsm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  dsm_pkg::dsm_item_type         head_item,
   output logic                          pop,
   output logic                          clr_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dsm_pkg::STATE_W-1:0]   rsp_state_now
);
   import dsm_pkg::*;

   localparam int ENT_W = STATE_W + 1;

   // transition table: {valid, dest}
   logic [ENT_W-1:0] tbl [TBL_DEPTH];
   logic [ENT_W-1:0] rd_ff;

   logic              clr_busy_ff;
   logic [TBL_AW-1:0] clr_cnt_ff;

   // accepting flags, cleared by the same sweep as the table
   logic acc_mem [NUM_STATES];
   logic acc_rd_ff;

   logic [STATE_W-1:0] cur_ff, cur_in;
   logic               dead_ff, dead_in;

   // lookup stage
   logic               b_valid_ff;
   dsm_item_type       b_item_ff;
   logic [TBL_AW-1:0]  b_addr_ff;
   logic               b_fwd_ff;
   logic [STATE_W-1:0] b_fwd_dest_ff;
   logic               b_acc_fwd_ff;
   logic               b_acc_fwd_val_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATE_W-1:0]  rsp_state_ff;

   logic                adv;
   logic                ent_valid;
   logic [STATE_W-1:0]  ent_dest;
   logic                acc_ent;
   logic                tbl_we, acc_we;
   logic [STATUS_W-1:0] status;
   logic [STATE_W-1:0]  state_out;
   logic [TBL_AW-1:0]   a_addr;
   logic                fwd_in;
   logic                acc_fwd_in;

   assign adv      = !rsp_valid_ff || !rsp_stall;
   assign pop      = adv && head_valid && !clr_busy_ff;
   assign clr_busy = clr_busy_ff;

   // a write from the transaction ahead is not yet in the read data
   assign ent_valid = b_fwd_ff ? 1'b1 : rd_ff[ENT_W-1];
   assign ent_dest  = b_fwd_ff ? b_fwd_dest_ff : rd_ff[STATE_W-1:0];
   assign acc_ent   = b_acc_fwd_ff ? b_acc_fwd_val_ff : acc_rd_ff;

   always_comb begin
      cur_in    = cur_ff;
      dead_in   = dead_ff;
      tbl_we    = 1'b0;
      acc_we    = 1'b0;
      status    = ST_LOADED;
      state_out = cur_ff;
      if (b_valid_ff) begin
         case (b_item_ff.op)
            OP_WRITE_EDGE: begin
               tbl_we = b_item_ff.args_ok && !ent_valid;
            end
            OP_WRITE_ACCEPT: begin
               acc_we = b_item_ff.args_ok;
            end
            OP_SYMBOL: begin
               if (!dead_ff) begin
                  if (b_item_ff.args_ok && state_in_range(cur_ff) && ent_valid) begin
                     cur_in = ent_dest;
                  end else begin
                     dead_in = 1'b1;
                  end
               end
               status    = dead_in ? ST_DEAD : ST_CONSUMED;
               state_out = cur_in;
            end
            default: begin   // end of string
               status = (!dead_ff && state_in_range(cur_ff) && acc_ent)
                        ? ST_ACCEPTED : ST_REJECTED;
               cur_in    = '0;
               dead_in   = 1'b0;
               state_out = '0;
            end
         endcase
      end
   end

   // issue: symbol lookups chain off the state the lookup stage leaves
   assign a_addr = (head_item.op == OP_SYMBOL) ? tbl_addr(cur_in, head_item.symbol)
                                               : head_item.edge_addr;
   assign fwd_in     = tbl_we && (b_addr_ff == a_addr);
   assign acc_fwd_in = acc_we && (b_item_ff.from_state == cur_in);

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         tbl[clr_cnt_ff]                 <= '0;
         acc_mem[clr_cnt_ff[ACC_AW-1:0]] <= 1'b0;
      end else if (adv) begin
         if (tbl_we) begin
            tbl[b_addr_ff] <= {1'b1, b_item_ff.to_state};
         end
         if (acc_we) begin
            acc_mem[ACC_AW'(b_item_ff.from_state)] <= b_item_ff.accept_value;
         end
      end
      if (pop) begin
         rd_ff     <= tbl[a_addr];
         acc_rd_ff <= acc_mem[ACC_AW'(cur_in)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         dead_ff      <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + TBL_AW'(1);
            if (clr_cnt_ff == TBL_AW'(TBL_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (adv) begin
            b_valid_ff   <= pop;
            rsp_valid_ff <= b_valid_ff;
            cur_ff       <= cur_in;
            dead_ff      <= dead_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_item_ff        <= head_item;
         b_addr_ff        <= a_addr;
         b_fwd_ff         <= fwd_in;
         b_fwd_dest_ff    <= b_item_ff.to_state;
         b_acc_fwd_ff     <= acc_fwd_in;
         b_acc_fwd_val_ff <= b_item_ff.accept_value;
      end
      if (adv && b_valid_ff) begin
         rsp_status_ff <= status;
         rsp_state_ff  <= state_out;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_state_now = rsp_state_ff;

endmodule

`default_nettype wire

FILE: sv/dfa_string_matcher.sv
// A result passes the front queue, lookup stage and response register once its request
// is accepted. Throughput: one transaction per cycle, symbols included, while rsp_stall
// is low; the next-state loop runs from the table's registered read data to the next read
// address. Reset: synchronous, active high. Afterwards the transition table and accepting
// flags are swept clear, one entry per cycle over all NUM_STATES * ALPHABET_SIZE (16384)
// entries; req_stall is held high for that sweep. Current state and dead flag reset to 0.
`default_nettype none

module dfa_string_matcher (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dsm_pkg::OP_W-1:0]      req_operation,
   input  logic [dsm_pkg::STATE_W-1:0]   req_from_state,
   input  logic [dsm_pkg::SYM_W-1:0]     req_symbol,
   input  logic [dsm_pkg::STATE_W-1:0]   req_to_state,
   input  logic                          req_accept_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dsm_pkg::STATE_W-1:0]   rsp_state_now
);
   import dsm_pkg::*;

   logic         clr_busy;
   logic         pop;
   logic         head_valid;
   dsm_item_type head_item;

   // Front: range-checks each transaction, computes the table slot of
   // transition writes, and buffers up to two transactions so req_stall
   // depends only on registered state.
   dsm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_from_state   (req_from_state),
      .req_symbol       (req_symbol),
      .req_to_state     (req_to_state),
      .req_accept_value (req_accept_value),
      .clr_busy         (clr_busy),
      .pop              (pop),
      .head_valid       (head_valid),
      .head_item        (head_item)
   );

   // Back: table and accepting-flag reads on issue, update of state / table /
   // flags in the lookup stage, then a response register. Duplicate transition
   // writes are dropped by a read-check-write with forwarding from the stage ahead.
   dsm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .clr_busy      (clr_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_state_now (rsp_state_now)
   );

`ifndef SYNTHESIS
   // nothing comes out while the table is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !rsp_valid)
      else $error("response during table clear");

   // end-of-string responses always report state 0
   a_end_state_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ACCEPTED || rsp_status == ST_REJECTED))
      |-> (rsp_state_now == '0))
      else $error("end-of-string response with nonzero state");

   // status stays within its defined codes
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_REJECTED))
      else $error("illegal response status");

   // no request is taken during the clear sweep
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> req_stall)
      else $error("request accepted during table clear");
`endif

endmodule

`default_nettype wire
